### rtl/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

   localparam int DIGIT_W     = 4;
   localparam int RADIX_W     = 5;
   localparam int FIELD_COUNT = 4;
   localparam int VALUE_W     = 16;
   localparam int CAP_W       = 17;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 21;
   localparam int PROD_W      = VALUE_W + RECIP_SHIFT;

   // floor(2^20 / radix), indexed by base digit (radix - 1)
   localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
      21'd1048576, 21'd524288, 21'd349525, 21'd262144,
      21'd209715,  21'd174762, 21'd149796, 21'd131072,
      21'd116508,  21'd104857, 21'd95325,  21'd87381,
      21'd80659,   21'd74898,  21'd69905,  21'd65536
   };

   typedef logic [FIELD_COUNT-1:0][DIGIT_W-1:0] mrc_digits_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] value_digit_0;
      logic [DIGIT_W-1:0] value_digit_1;
      logic [DIGIT_W-1:0] value_digit_2;
      logic [DIGIT_W-1:0] value_digit_3;
      logic [DIGIT_W-1:0] source_base_0;
      logic [DIGIT_W-1:0] source_base_1;
      logic [DIGIT_W-1:0] source_base_2;
      logic [DIGIT_W-1:0] source_base_3;
      logic [DIGIT_W-1:0] target_base_0;
      logic [DIGIT_W-1:0] target_base_1;
      logic [DIGIT_W-1:0] target_base_2;
      logic [DIGIT_W-1:0] target_base_3;
   } mrc_req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] result_digit_0;
      logic [DIGIT_W-1:0] result_digit_1;
      logic [DIGIT_W-1:0] result_digit_2;
      logic [DIGIT_W-1:0] result_digit_3;
      logic               overflow;
   } mrc_rsp_type;

   // in-flight conversion: remaining quotient, target bases still to use
   // (next one at index 0), digits produced so far (shifted in from the top)
   typedef struct packed {
      logic [VALUE_W-1:0] rest;
      mrc_digits_type     tbase;
      mrc_digits_type     digit;
      logic               over;
   } mrc_work_type;

   function automatic logic [RADIX_W-1:0] radix_of(input logic [DIGIT_W-1:0] base);
      return {1'b0, base} + RADIX_W'(1);
   endfunction

endpackage

`default_nettype wire

### rtl/mrc_value.sv
`default_nettype none

module mrc_value (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  mrc_pkg::mrc_req_type in_req,
   output logic                 out_valid,
   output mrc_pkg::mrc_work_type out_work
);
   import mrc_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff, valid_in;

   // stage 1
   logic [8:0]         sum01_1_ff, sum01_1_in;
   logic [8:0]         w2_1_ff, w2_1_in;
   logic [8:0]         t01_1_ff, t01_1_in;
   logic [8:0]         t23_1_ff, t23_1_in;
   logic [DIGIT_W-1:0] d2_1_ff, d3_1_ff;
   logic [RADIX_W-1:0] r2_1_ff;
   mrc_digits_type     tb_1_ff, tb_1_in;

   // stage 2
   logic [11:0]        term2_2_ff, term2_2_in;
   logic [12:0]        w3_2_ff, w3_2_in;
   logic [CAP_W-1:0]   cap_2_ff, cap_2_in;
   logic [8:0]         sum01_2_ff;
   logic [DIGIT_W-1:0] d3_2_ff;
   mrc_digits_type     tb_2_ff;

   // stage 3
   logic [15:0]        term3_3_ff, term3_3_in;
   logic [12:0]        part_3_ff, part_3_in;
   logic [CAP_W-1:0]   cap_3_ff;
   mrc_digits_type     tb_3_ff;

   // stage 4
   mrc_work_type       work_4_ff, work_4_in;
   logic [CAP_W-1:0]   value_4;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      sum01_1_in = 9'(in_req.value_digit_0)
                 + 9'(in_req.value_digit_1) * 9'(radix_of(in_req.source_base_0));
      w2_1_in    = 9'(radix_of(in_req.source_base_0)) * 9'(radix_of(in_req.source_base_1));
      t01_1_in   = 9'(radix_of(in_req.target_base_0)) * 9'(radix_of(in_req.target_base_1));
      t23_1_in   = 9'(radix_of(in_req.target_base_2)) * 9'(radix_of(in_req.target_base_3));
      tb_1_in    = {in_req.target_base_3, in_req.target_base_2,
                    in_req.target_base_1, in_req.target_base_0};
   end

   always_comb begin
      term2_2_in = 12'(d2_1_ff) * 12'(w2_1_ff);
      w3_2_in    = 13'(w2_1_ff) * 13'(r2_1_ff);
      cap_2_in   = CAP_W'(t01_1_ff) * CAP_W'(t23_1_ff);
   end

   always_comb begin
      term3_3_in = 16'(d3_2_ff) * 16'(w3_2_ff);
      part_3_in  = 13'(sum01_2_ff) + 13'(term2_2_ff);
   end

   always_comb begin
      value_4         = CAP_W'(part_3_ff) + CAP_W'(term3_3_ff);
      work_4_in.rest  = value_4[VALUE_W-1:0];
      work_4_in.tbase = tb_3_ff;
      work_4_in.digit = '0;
      work_4_in.over  = (value_4 >= cap_3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum01_1_ff <= sum01_1_in;
      w2_1_ff    <= w2_1_in;
      t01_1_ff   <= t01_1_in;
      t23_1_ff   <= t23_1_in;
      d2_1_ff    <= in_req.value_digit_2;
      d3_1_ff    <= in_req.value_digit_3;
      r2_1_ff    <= radix_of(in_req.source_base_2);
      tb_1_ff    <= tb_1_in;

      term2_2_ff <= term2_2_in;
      w3_2_ff    <= w3_2_in;
      cap_2_ff   <= cap_2_in;
      sum01_2_ff <= sum01_1_ff;
      d3_2_ff    <= d3_1_ff;
      tb_2_ff    <= tb_1_ff;

      term3_3_ff <= term3_3_in;
      part_3_ff  <= part_3_in;
      cap_3_ff   <= cap_2_ff;
      tb_3_ff    <= tb_2_ff;

      work_4_ff  <= work_4_in;
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_work  = work_4_ff;

endmodule

`default_nettype wire

### rtl/mrc_digit.sv
`default_nettype none

module mrc_digit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mrc_pkg::mrc_work_type in_work,
   output logic                  out_valid,
   output mrc_pkg::mrc_work_type out_work
);
   import mrc_pkg::*;

   localparam int QR_W  = VALUE_W + RADIX_W;
   localparam int REM_W = VALUE_W + 1;

   logic               valid_a_ff, valid_b_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   mrc_work_type       work_a_ff;
   mrc_work_type       work_b_ff, work_b_in;

   logic [RADIX_W-1:0] radix;
   logic [VALUE_W-1:0] q_est;
   logic [QR_W-1:0]    qr;
   logic [REM_W-1:0]   rem;
   logic [DIGIT_W-1:0] new_digit;
   logic [VALUE_W-1:0] quotient;

   // quotient estimate by reciprocal; low by at most one
   assign prod_in = PROD_W'(in_work.rest) * PROD_W'(RECIP_TABLE[in_work.tbase[0]]);

   always_comb begin
      radix = radix_of(work_a_ff.tbase[0]);
      q_est = prod_ff[RECIP_SHIFT +: VALUE_W];
      qr    = QR_W'(q_est) * QR_W'(radix);
      rem   = REM_W'(work_a_ff.rest) - qr[REM_W-1:0];
      if (rem >= REM_W'(radix)) begin
         new_digit = DIGIT_W'(rem - REM_W'(radix));
         quotient  = q_est + VALUE_W'(1);
      end else begin
         new_digit = DIGIT_W'(rem);
         quotient  = q_est;
      end
      work_b_in.rest  = quotient;
      work_b_in.tbase = {DIGIT_W'(0), work_a_ff.tbase[FIELD_COUNT-1:1]};
      work_b_in.digit = {new_digit, work_a_ff.digit[FIELD_COUNT-1:1]};
      work_b_in.over  = work_a_ff.over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      work_a_ff <= in_work;
      work_b_ff <= work_b_in;
   end

   assign out_valid = valid_b_ff;
   assign out_work  = work_b_ff;

endmodule

`default_nettype wire

### rtl/mixed_radix_converter_unit.sv
// Channel   Ports                      Direction  Transfer
// request   start, busy, req_data      in         start && !busy
// response  rsp_strobe, rsp_data       out        rsp_strobe (one cycle)
//
// Path: value and capacity are built in mrc_value, then the reciprocal divider chain
// has an mrc_digit per target digit, then the output register. One transfer per cycle.
// busy is always low; nothing in the pipeline stalls.
// Synchronous reset clears valid bits only; no warm-up after reset.
`default_nettype none

module mixed_radix_converter_unit #(
   parameter int NUM_DIGITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mrc_pkg::mrc_req_type req_data,
   output logic                 rsp_strobe,
   output mrc_pkg::mrc_rsp_type rsp_data
);
   import mrc_pkg::*;

   localparam logic [FIELD_COUNT-1:0] USE_MASK = FIELD_COUNT'((1 << NUM_DIGITS) - 1);

   mrc_req_type  req_masked;
   logic         req_transfer;

   logic [FIELD_COUNT:0] chain_valid;
   mrc_work_type         chain_work [FIELD_COUNT+1];

   logic         rsp_valid_ff;
   mrc_rsp_type  rsp_data_ff, rsp_data_in;
   mrc_work_type last_work;

   assign busy         = 1'b0;
   assign req_transfer = start && !busy;

   // unused positions become digit 0, radix 1
   always_comb begin
      req_masked               = req_data;
      req_masked.value_digit_0 = USE_MASK[0] ? req_data.value_digit_0 : '0;
      req_masked.value_digit_1 = USE_MASK[1] ? req_data.value_digit_1 : '0;
      req_masked.value_digit_2 = USE_MASK[2] ? req_data.value_digit_2 : '0;
      req_masked.value_digit_3 = USE_MASK[3] ? req_data.value_digit_3 : '0;
      req_masked.source_base_0 = USE_MASK[0] ? req_data.source_base_0 : '0;
      req_masked.source_base_1 = USE_MASK[1] ? req_data.source_base_1 : '0;
      req_masked.source_base_2 = USE_MASK[2] ? req_data.source_base_2 : '0;
      req_masked.source_base_3 = USE_MASK[3] ? req_data.source_base_3 : '0;
      req_masked.target_base_0 = USE_MASK[0] ? req_data.target_base_0 : '0;
      req_masked.target_base_1 = USE_MASK[1] ? req_data.target_base_1 : '0;
      req_masked.target_base_2 = USE_MASK[2] ? req_data.target_base_2 : '0;
      req_masked.target_base_3 = USE_MASK[3] ? req_data.target_base_3 : '0;
   end

   mrc_value u_value (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_transfer),
      .in_req    (req_masked),
      .out_valid (chain_valid[0]),
      .out_work  (chain_work[0])
   );

   for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_digit
      mrc_digit u_digit (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_work   (chain_work[g]),
         .out_valid (chain_valid[g+1]),
         .out_work  (chain_work[g+1])
      );
   end

   always_comb begin
      last_work                  = chain_work[FIELD_COUNT];
      rsp_data_in.overflow       = last_work.over;
      rsp_data_in.result_digit_0 = last_work.over ? '0 : last_work.digit[0];
      rsp_data_in.result_digit_1 = last_work.over ? '0 : last_work.digit[1];
      rsp_data_in.result_digit_2 = last_work.over ? '0 : last_work.digit[2];
      rsp_data_in.result_digit_3 = last_work.over ? '0 : last_work.digit[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[FIELD_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire
